[rtl/rfu_pkg.sv]
// ----------------------------------------------------------------------------
// Readout frame unpacker package
// Parse phases, field codes, marker constants and the result record that are
// shared by the unpacker files.
// ----------------------------------------------------------------------------
package rfu_pkg;

  // Parse phase of the frame walker.
  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_ORB_LO = 3'd1,
    PH_ORB_HI = 3'd2,
    PH_BLOCK  = 3'd3,
    PH_OPT    = 3'd4,
    PH_CHAN   = 3'd5,
    PH_CRC    = 3'd6,
    PH_TRAIL  = 3'd7
  } phase_t;

  // Result status codes.
  localparam logic [2:0] ST_FRAME      = 3'd0;
  localparam logic [2:0] ST_UNK_FLAG   = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd3;
  localparam logic [2:0] ST_ORBIT      = 3'd4;

  // Item kinds.
  localparam logic FUNC_HEADER  = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_RAW_FLAG     = 1'b0;
  localparam logic CFG_CLUSTER_FLAG = 1'b1;

  localparam logic [7:0] RAW_FLAG_RESET     = 8'h90;
  localparam logic [7:0] CLUSTER_FLAG_RESET = 8'h80;

  // Frame header markers.
  localparam logic [3:0] HDR_BEGIN_MARK = 4'h5;
  localparam logic [3:0] HDR_LOW_MARK   = 4'h0;
  localparam logic [3:0] HDR_FORMAT     = 4'h2;

  // Payload word markers.
  localparam logic [15:0] PAD_WORD = 16'hFFFF;
  localparam logic [3:0]  NIB_BC   = 4'hA;
  localparam logic [3:0]  NIB_EC   = 4'hC;
  localparam logic [3:0]  NIB_ID   = 4'hE;

  // Optional word stage: how far the BC, EC, ID sequence has advanced.
  localparam logic [1:0] OPT_NONE    = 2'd0;
  localparam logic [1:0] OPT_AFTER_BC = 2'd1;
  localparam logic [1:0] OPT_AFTER_EC = 2'd2;
  localparam logic [1:0] OPT_AFTER_ID = 2'd3;

  // Presence bits.
  localparam int unsigned PRES_BC  = 0;
  localparam int unsigned PRES_EC  = 1;
  localparam int unsigned PRES_ID  = 2;
  localparam int unsigned PRES_CRC = 3;

  localparam int unsigned CHAN_SLOTS = 8;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] source_id;
    logic [3:0]  link_group;
    logic [3:0]  link_fiber;
    logic [3:0]  presence;
    logic [15:0] bunch_word;
    logic [15:0] event_word;
    logic [15:0] chip_id_word;
    logic [15:0] crc_word;
    logic [63:0] channels_high;
    logic [63:0] channels_low;
    logic [31:0] orbit_counter;
  } res_t;

endpackage

[rtl/readout_frame_unpacker.sv]
// ----------------------------------------------------------------------------
// Readout frame unpacker
// Walks a detector readout frame one item at a time and emits one record per
// chip block, plus records for the orbit counter and for header faults.
// ----------------------------------------------------------------------------
// Output: each result is registered, in the output register or in the skid stage.
// Throughput: one item per cycle, since each item needs only a few compares and a
//   register update; the input stalls only while the output register and the skid
//   stage behind it both hold results.
// Reset: rst is synchronous and active high; it returns the parser to waiting for
//   a frame header, empties the output stages and restores both flag registers.
module readout_frame_unpacker
  import rfu_pkg::*;
#(
  parameter int unsigned CHANNEL_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [63:0] word_value,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [11:0] source_id,
  output logic [3:0]  link_group,
  output logic [3:0]  link_fiber,
  output logic [3:0]  presence,
  output logic [15:0] bunch_word,
  output logic [15:0] event_word,
  output logic [15:0] chip_id_word,
  output logic [15:0] crc_word,
  output logic [63:0] channels_high,
  output logic [63:0] channels_low,
  output logic [31:0] orbit_counter
);

  // The channel count is cast to four bits; CHANNEL_WORDS is not checked against
  // the eight channel slots, and a value above 15 is truncated.
  localparam logic [3:0] CHAN_LIMIT = 4'(CHANNEL_WORDS);

  // Flag registers.
  logic [7:0] raw_flag;
  logic [7:0] cluster_flag;

  // Parse state.
  phase_t      phase;
  phase_t      phase_next;
  logic [11:0] held_source_id;
  logic [3:0]  held_group;
  logic [3:0]  held_fiber;
  logic        raw_block;
  logic [3:0]  held_presence;
  logic [15:0] held_bc;
  logic [15:0] held_ec;
  logic [15:0] held_id;
  logic [15:0] held_crc;
  logic [15:0] channel_store [CHAN_SLOTS];
  logic [1:0]  opt_stage;
  logic [3:0]  chan_count;
  logic [15:0] orbit_low_half;

  // Output register and skid stage.
  res_t out_reg;
  res_t skid_reg;
  logic skid_valid;

  // Decoded item.
  logic        acc_in;
  logic [15:0] w;
  logic [3:0]  hdr_begin;
  logic [3:0]  hdr_low;
  logic [3:0]  hdr_format;
  logic [11:0] hdr_sid;
  logic        hdr_marks_ok;
  logic        hdr_ok;
  logic [3:0]  nib;
  logic        is_raw_flag;
  logic        is_cluster_flag;
  logic        opt_bc;
  logic        opt_ec;
  logic        opt_id;
  logic        opt_hit;
  logic [3:0]  chan_inc;
  logic        res_fire;
  res_t        res;
  logic        out_take;

  // A new item is held off only when both output stages are full, which is
  // the one case where a result it causes would have nowhere to go.
  assign in_stall  = skid_valid;
  assign acc_in    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign w          = word_value[15:0];
  assign hdr_begin  = word_value[63:60];
  assign hdr_low    = word_value[3:0];
  assign hdr_format = word_value[7:4];
  assign hdr_sid    = word_value[19:8];

  assign hdr_marks_ok = (hdr_begin == HDR_BEGIN_MARK) && (hdr_low == HDR_LOW_MARK);
  assign hdr_ok       = hdr_marks_ok && (hdr_format == HDR_FORMAT);

  // Raw mode wins when both flag registers hold the same value.
  assign is_raw_flag     = (w[15:8] == raw_flag);
  assign is_cluster_flag = (w[15:8] == cluster_flag);

  // Optional words must come in the order BC, EC, ID; any may be missing.
  assign nib     = w[15:12];
  assign opt_bc  = (opt_stage == OPT_NONE) && (nib == NIB_BC);
  assign opt_ec  = (opt_stage <= OPT_AFTER_BC) && (nib == NIB_EC);
  assign opt_id  = (opt_stage <= OPT_AFTER_EC) && (nib == NIB_ID);
  assign opt_hit = opt_bc || opt_ec || opt_id;

  assign chan_inc = chan_count + 4'd1;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_flag     <= RAW_FLAG_RESET;
      cluster_flag <= CLUSTER_FLAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RAW_FLAG:     raw_flag     <= cfg_data;
        CFG_CLUSTER_FLAG: cluster_flag <= cfg_data;
        default:          raw_flag     <= raw_flag;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Next parse phase. A header item restarts parsing from any phase; a
  // payload word while waiting for a header is dropped.
  // --------------------------------------------------------------------------
  always_comb begin
    phase_next = phase;
    if (acc_in) begin
      if (func == FUNC_HEADER) begin
        phase_next = hdr_ok ? PH_ORB_LO : PH_WAIT;
      end else begin
        unique case (phase)
          PH_WAIT:   phase_next = PH_WAIT;
          PH_ORB_LO: phase_next = PH_ORB_HI;
          PH_ORB_HI: phase_next = PH_BLOCK;
          PH_BLOCK: begin
            if ((w != PAD_WORD) && (is_raw_flag || is_cluster_flag)) begin
              phase_next = PH_OPT;
            end
          end
          PH_OPT: begin
            priority if (opt_hit) begin
              phase_next = PH_OPT;
            end else if (raw_block) begin
              // The first non-optional word is channel zero.
              phase_next = (CHAN_LIMIT <= 4'd1) ? PH_CRC : PH_CHAN;
            end else begin
              // Cluster mode: this word is the trailer.
              phase_next = PH_BLOCK;
            end
          end
          PH_CHAN:  phase_next = (chan_inc >= CHAN_LIMIT) ? PH_CRC : PH_CHAN;
          PH_CRC:   phase_next = PH_TRAIL;
          PH_TRAIL: phase_next = PH_BLOCK;
          default:  phase_next = PH_WAIT;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result formation. Fields that mean nothing for a given status are zero.
  // A block record is built wholly from held state: the word that closes the
  // block (trailer, or first plain word in cluster mode) carries nothing.
  // --------------------------------------------------------------------------
  always_comb begin
    res_fire = 1'b0;
    res      = '0;
    if (acc_in) begin
      if (func == FUNC_HEADER) begin
        if (!hdr_ok) begin
          res_fire      = 1'b1;
          res.status    = hdr_marks_ok ? ST_BAD_FORMAT : ST_BAD_HEADER;
          res.source_id = hdr_sid;
        end
      end else begin
        unique case (phase)
          PH_ORB_HI: begin
            res_fire          = 1'b1;
            res.status        = ST_ORBIT;
            res.source_id     = held_source_id;
            res.orbit_counter = {w, orbit_low_half};
          end
          PH_BLOCK: begin
            if ((w != PAD_WORD) && !is_raw_flag && !is_cluster_flag) begin
              res_fire      = 1'b1;
              res.status    = ST_UNK_FLAG;
              res.source_id = held_source_id;
            end
          end
          PH_OPT, PH_TRAIL: begin
            if ((phase == PH_TRAIL) || (!opt_hit && !raw_block)) begin
              res_fire          = 1'b1;
              res.status        = ST_FRAME;
              res.source_id     = held_source_id;
              res.link_group    = held_group;
              res.link_fiber    = held_fiber;
              res.presence      = held_presence;
              res.bunch_word    = held_bc;
              res.event_word    = held_ec;
              res.chip_id_word  = held_id;
              res.crc_word      = held_crc;
              res.channels_high = {channel_store[0], channel_store[1],
                                   channel_store[2], channel_store[3]};
              res.channels_low  = {channel_store[4], channel_store[5],
                                   channel_store[6], channel_store[7]};
            end
          end
          default: res_fire = 1'b0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Parse state registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
    end else begin
      phase <= phase_next;
    end
  end

  // Held frame and block data. These are always written before they are
  // read, so they take no reset.
  always_ff @(posedge clk) begin
    if (acc_in) begin
      if (func == FUNC_HEADER) begin
        if (hdr_ok) begin
          held_source_id <= hdr_sid;
        end
      end else begin
        unique case (phase)
          PH_ORB_LO: orbit_low_half <= w;
          PH_BLOCK: begin
            if ((w != PAD_WORD) && (is_raw_flag || is_cluster_flag)) begin
              // Open a new block with all optional and channel data cleared.
              raw_block     <= is_raw_flag;
              held_group    <= w[7:4];
              held_fiber    <= w[3:0];
              held_presence <= '0;
              held_bc       <= '0;
              held_ec       <= '0;
              held_id       <= '0;
              held_crc      <= '0;
              opt_stage     <= OPT_NONE;
              chan_count    <= '0;
              for (int i = 0; i < CHAN_SLOTS; i++) begin
                channel_store[i] <= '0;
              end
            end
          end
          PH_OPT: begin
            priority if (opt_bc) begin
              held_bc                <= w;
              held_presence[PRES_BC] <= 1'b1;
              opt_stage              <= OPT_AFTER_BC;
            end else if (opt_ec) begin
              held_ec                <= w;
              held_presence[PRES_EC] <= 1'b1;
              opt_stage              <= OPT_AFTER_EC;
            end else if (opt_id) begin
              held_id                <= w;
              held_presence[PRES_ID] <= 1'b1;
              opt_stage              <= OPT_AFTER_ID;
            end else if (raw_block) begin
              channel_store[0] <= w;
              chan_count       <= 4'd1;
            end else begin
              // Cluster mode trailer: the block record leaves from held state.
              held_crc <= held_crc;
            end
          end
          PH_CHAN: begin
            channel_store[chan_count[2:0]] <= w;
            chan_count                     <= chan_inc;
          end
          PH_CRC: begin
            held_crc                <= w;
            held_presence[PRES_CRC] <= 1'b1;
          end
          default: held_crc <= held_crc;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register with a skid stage behind it. A result goes straight to
  // the output register when that register is free or being taken; otherwise
  // it parks in the skid stage, which then holds off further items.
  // --------------------------------------------------------------------------
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take || !out_valid) begin
        out_valid  <= skid_valid || res_fire;
        skid_valid <= 1'b0;
      end else if (res_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (res_fire) begin
        out_reg <= res;
      end
    end else if (res_fire) begin
      skid_reg <= res;
    end
  end

  assign status        = out_reg.status;
  assign source_id     = out_reg.source_id;
  assign link_group    = out_reg.link_group;
  assign link_fiber    = out_reg.link_fiber;
  assign presence      = out_reg.presence;
  assign bunch_word    = out_reg.bunch_word;
  assign event_word    = out_reg.event_word;
  assign chip_id_word  = out_reg.chip_id_word;
  assign crc_word      = out_reg.crc_word;
  assign channels_high = out_reg.channels_high;
  assign channels_low  = out_reg.channels_low;
  assign orbit_counter = out_reg.orbit_counter;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // The skid stage fills only behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  // A result is never formed while both output stages are full.
  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    res_fire |-> !skid_valid)
    else $error("result formed with no room in the output stages");

  // While channel words are collected the count stays inside the block.
  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CHAN) |-> ((chan_count >= 4'd1) && (chan_count < CHAN_LIMIT)))
    else $error("channel count out of range in channel phase");

  // The channel and CRC phases are entered only for a raw mode block.
  a_crc_raw_only: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CRC || phase == PH_CHAN) |-> raw_block)
    else $error("channel or CRC phase entered in cluster mode");

endmodule
